FILE: src/ehc_pkg.sv
// constants and codes shared by the ethernet ipv4 header classifier
`default_nettype none

package ehc_pkg;

    // header lengths in bytes, the minimum header length in words, and the count limit
    localparam logic [7:0] ETH_LEN       = 8'd14;
    localparam logic [7:0] IP_MIN_LEN    = 8'd20;
    localparam logic [7:0] TCP_MIN_LEN   = 8'd20;
    localparam logic [7:0] UDP_LEN       = 8'd8;
    localparam logic [7:0] ICMP_LEN      = 8'd8;
    localparam logic [7:0] ARP_FRAME_LEN = 8'd42;
    localparam logic [3:0] MIN_WORDS     = 4'd5;
    localparam logic [7:0] COUNT_MAX     = 8'd255;

    // fixed field positions
    localparam logic [7:0] POS_TYPE_HI = 8'd12;
    localparam logic [7:0] POS_TYPE_LO = 8'd13;
    localparam logic [7:0] POS_IHL     = 8'd14;
    localparam logic [7:0] POS_ARP_HI  = 8'd20;
    localparam logic [7:0] POS_ARP_LO  = 8'd21;
    localparam logic [7:0] POS_PROTO   = 8'd23;
    localparam logic [7:0] POS_DOFF    = 8'd12;

    // ethertypes and ip protocols
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] TYPE_ARP   = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // result categories
    localparam logic [2:0] CAT_NONE = 3'd0;
    localparam logic [2:0] CAT_TCP  = 3'd1;
    localparam logic [2:0] CAT_UDP  = 3'd2;
    localparam logic [2:0] CAT_ICMP = 3'd3;
    localparam logic [2:0] CAT_ARP  = 3'd4;

endpackage

`default_nettype wire

FILE: src/ethernet_ipv4_header_classifier.sv
// ethernet / ipv4 / tcp-udp-icmp / arp header classifier, one byte per cycle
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  byte    | byte_valid, byte_stall     | data_byte[7:0], last_byte
//  result  | result_valid, result_stall | parse_ok, category[2:0], ether_type,
//          |                            | ip_protocol, source_port, dest_port,
//          |                            | icmp_kind, arp_operation
//
//  one byte transaction per cycle while byte_stall is low; a byte goes through the input
//  register, then the capture and length check logic, and the frame result lands in the
//  result register when the last byte moves on from the input register
//  rst_n is asynchronous and clears the frame state and both valid flags
//  byte_stall rises only while a last byte waits in the input register and the result
//  register still holds an earlier result that result_stall keeps from leaving
`default_nettype none

module ethernet_ipv4_header_classifier
    import ehc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             parse_ok,
    output logic [2:0]       category,
    output logic [15:0]      ether_type,
    output logic [7:0]       ip_protocol,
    output logic [15:0]      source_port,
    output logic [15:0]      dest_port,
    output logic [7:0]       icmp_kind,
    output logic [15:0]      arp_operation
);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // frame state
    logic [7:0]  count_reg,    count_next;
    logic [15:0] type_reg,     type_next;
    logic [3:0]  ihl_reg,      ihl_next;
    logic [7:0]  proto_reg,    proto_next;
    logic [3:0]  doff_reg,     doff_next;
    logic [15:0] sport_reg,    sport_next;
    logic [15:0] dport_reg,    dport_next;
    logic [7:0]  icmp_reg,     icmp_next;
    logic [15:0] arp_reg,      arp_next;

    // state after the byte in the input register is captured
    logic [7:0]  cap_count;
    logic [15:0] cap_type;
    logic [3:0]  cap_ihl;
    logic [7:0]  cap_proto;
    logic [3:0]  cap_doff;
    logic [15:0] cap_sport;
    logic [15:0] cap_dport;
    logic [7:0]  cap_icmp;
    logic [15:0] cap_arp;

    // frame result, computed from the captured state
    logic        res_ok;
    logic [2:0]  res_cat;
    logic [15:0] res_et;
    logic [7:0]  res_ipp;
    logic [15:0] res_sp;
    logic [15:0] res_dp;
    logic [7:0]  res_ik;
    logic [15:0] res_ao;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        ok_reg;
    logic [2:0]  cat_reg;
    logic [15:0] et_reg;
    logic [7:0]  ipp_reg;
    logic [15:0] sp_reg;
    logic [15:0] dp_reg;
    logic [7:0]  ik_reg;
    logic [15:0] ao_reg;

    logic advance;
    logic frame_end;
    logic byte_take;

    // the byte in the input register moves on unless it ends a frame and the
    // result register is full and held
    assign advance    = in_valid_reg && !(in_last_reg && out_valid_reg && result_stall);
    assign frame_end  = advance && in_last_reg;
    assign byte_stall = in_valid_reg && !advance;
    assign byte_take  = byte_valid && !byte_stall;

    // capture at fixed offsets and at the layer 4 offset set by the ihl
    always_comb
    begin
        logic [7:0] pos;
        logic [7:0] l4;
        pos = count_reg;
        l4  = ETH_LEN + {2'b00, ihl_reg, 2'b00};

        cap_type  = type_reg;
        cap_ihl   = ihl_reg;
        cap_proto = proto_reg;
        cap_doff  = doff_reg;
        cap_sport = sport_reg;
        cap_dport = dport_reg;
        cap_icmp  = icmp_reg;
        cap_arp   = arp_reg;

        if (pos == POS_TYPE_HI) cap_type[15:8] = in_byte_reg;
        if (pos == POS_TYPE_LO) cap_type[7:0]  = in_byte_reg;
        if (pos == POS_IHL)     cap_ihl        = in_byte_reg[3:0];
        if (pos == POS_ARP_HI)  cap_arp[15:8]  = in_byte_reg;
        if (pos == POS_ARP_LO)  cap_arp[7:0]   = in_byte_reg;
        if (pos == POS_PROTO)   cap_proto      = in_byte_reg;

        // layer 4 offsets only count once the ihl byte has gone by
        if (pos > POS_IHL)
        begin
            if (pos == l4)
            begin
                cap_sport[15:8] = in_byte_reg;
                cap_icmp        = in_byte_reg;
            end
            if (pos == l4 + 8'd1)     cap_sport[7:0]  = in_byte_reg;
            if (pos == l4 + 8'd2)     cap_dport[15:8] = in_byte_reg;
            if (pos == l4 + 8'd3)     cap_dport[7:0]  = in_byte_reg;
            if (pos == l4 + POS_DOFF) cap_doff        = in_byte_reg[7:4];
        end

        // saturating byte count
        cap_count = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
    end

    // length checks and classification on the captured state
    always_comb
    begin
        logic [7:0] total;
        logic [7:0] l4;
        logic [7:0] rem;
        logic [7:0] doff_len;
        total    = cap_count;
        l4       = ETH_LEN + {2'b00, cap_ihl, 2'b00};
        rem      = total - l4;
        doff_len = {2'b00, cap_doff, 2'b00};

        res_ok  = 1'b0;
        res_cat = CAT_NONE;
        res_et  = '0;
        res_ipp = '0;
        res_sp  = '0;
        res_dp  = '0;
        res_ik  = '0;
        res_ao  = '0;

        if (total >= ETH_LEN)
        begin
            res_et = cap_type;
            res_ok = 1'b1;
            if (cap_type == TYPE_IPV4)
            begin
                if (total < ETH_LEN + IP_MIN_LEN || cap_ihl < MIN_WORDS || total < l4)
                begin
                    res_ok = 1'b0;
                end
                else
                begin
                    res_ipp = cap_proto;
                    if (cap_proto == PROTO_TCP)
                    begin
                        if (rem < TCP_MIN_LEN || cap_doff < MIN_WORDS || rem < doff_len)
                        begin
                            res_ok = 1'b0;
                        end
                        else
                        begin
                            res_cat = CAT_TCP;
                            res_sp  = cap_sport;
                            res_dp  = cap_dport;
                        end
                    end
                    else if (cap_proto == PROTO_UDP)
                    begin
                        if (rem < UDP_LEN)
                        begin
                            res_ok = 1'b0;
                        end
                        else
                        begin
                            res_cat = CAT_UDP;
                            res_sp  = cap_sport;
                            res_dp  = cap_dport;
                        end
                    end
                    else if (cap_proto == PROTO_ICMP)
                    begin
                        if (rem < ICMP_LEN)
                        begin
                            res_ok = 1'b0;
                        end
                        else
                        begin
                            res_cat = CAT_ICMP;
                            res_ik  = cap_icmp;
                        end
                    end
                end
            end
            else if (cap_type == TYPE_ARP)
            begin
                if (total < ARP_FRAME_LEN)
                begin
                    res_ok = 1'b0;
                end
                else
                begin
                    res_cat = CAT_ARP;
                    res_ao  = cap_arp;
                end
            end
        end
    end

    // frame state: capture when a byte moves on, hold otherwise, clear after the last byte
    always_comb
    begin
        count_next = count_reg;
        type_next  = type_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        doff_next  = doff_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        icmp_next  = icmp_reg;
        arp_next   = arp_reg;
        if (frame_end)
        begin
            count_next = '0;
            type_next  = '0;
            ihl_next   = '0;
            proto_next = '0;
            doff_next  = '0;
            sport_next = '0;
            dport_next = '0;
            icmp_next  = '0;
            arp_next   = '0;
        end
        else if (advance)
        begin
            count_next = cap_count;
            type_next  = cap_type;
            ihl_next   = cap_ihl;
            proto_next = cap_proto;
            doff_next  = cap_doff;
            sport_next = cap_sport;
            dport_next = cap_dport;
            icmp_next  = cap_icmp;
            arp_next   = cap_arp;
        end
    end

    // input register fills on a byte transaction, empties when it moves on
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    // result register fills at frame end, empties on a result transaction
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (frame_end)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            type_reg      <= '0;
            ihl_reg       <= '0;
            proto_reg     <= '0;
            doff_reg      <= '0;
            sport_reg     <= '0;
            dport_reg     <= '0;
            icmp_reg      <= '0;
            arp_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            type_reg      <= type_next;
            ihl_reg       <= ihl_next;
            proto_reg     <= proto_next;
            doff_reg      <= doff_next;
            sport_reg     <= sport_next;
            dport_reg     <= dport_next;
            icmp_reg      <= icmp_next;
            arp_reg       <= arp_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (frame_end)
        begin
            ok_reg  <= res_ok;
            cat_reg <= res_cat;
            et_reg  <= res_et;
            ipp_reg <= res_ipp;
            sp_reg  <= res_sp;
            dp_reg  <= res_dp;
            ik_reg  <= res_ik;
            ao_reg  <= res_ao;
        end
    end

    assign result_valid  = out_valid_reg;
    assign parse_ok      = ok_reg;
    assign category      = cat_reg;
    assign ether_type    = et_reg;
    assign ip_protocol   = ipp_reg;
    assign source_port   = sp_reg;
    assign dest_port     = dp_reg;
    assign icmp_kind     = ik_reg;
    assign arp_operation = ao_reg;

    // frame state starts over after every last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (count_reg == '0 && type_reg == '0 && ihl_reg == '0))
        else $error("frame state not cleared after last byte");

    // a handled category is never reported on a failed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (category == CAT_NONE || parse_ok))
        else $error("category set on failed frame");

    // ports only come with tcp or udp
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (source_port != '0 || dest_port != '0))
            |-> (category == CAT_TCP || category == CAT_UDP))
        else $error("ports reported outside tcp or udp");

    // icmp type and arp opcode only with their own category
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (icmp_kind != '0)) |-> (category == CAT_ICMP))
        else $error("icmp type reported outside icmp");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (arp_operation != '0)) |-> (category == CAT_ARP))
        else $error("arp opcode reported outside arp");

    // a stall on the byte side comes only from a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (in_valid_reg && in_last_reg && out_valid_reg && result_stall))
        else $error("byte stall without a held result");

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for the ethernet ipv4 header classifier: stimulus, predictor, result checks
module tb;
    import ehc_pkg::*;

    localparam int WORD_BYTES  = 4;
    localparam int FRAME_MAX   = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    // kinds of frames the generator builds
    typedef enum int {
        FRAME_TCP,
        FRAME_UDP,
        FRAME_ICMP,
        FRAME_ARP,
        FRAME_OTHER_TYPE,
        FRAME_OTHER_PROTO,
        FRAME_NOISE
    } frame_kind_t;

    // one per-frame classification, as the result channel carries it
    typedef struct packed {
        logic        ok;
        logic [2:0]  cat;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  icmp;
        logic [15:0] arp_op;
    } frame_summary_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        parse_ok;
    logic [2:0]  category;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  icmp_kind;
    logic [15:0] arp_operation;

    int idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;

    frame_summary_t expected_summaries[$];
    logic [7:0]     pkt [0:FRAME_MAX-1];

    // predictor copy of the per-frame capture state
    logic [7:0]  seen_count = 8'd0;
    logic [15:0] seen_type = 16'd0;
    logic [3:0]  seen_ihl = 4'd0;
    logic [7:0]  seen_proto = 8'd0;
    logic [3:0]  seen_doff = 4'd0;
    logic [15:0] seen_sport = 16'd0;
    logic [15:0] seen_dport = 16'd0;
    logic [7:0]  seen_icmp = 8'd0;
    logic [15:0] seen_arp = 16'd0;

    ethernet_ipv4_header_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .parse_ok      (parse_ok),
        .category      (category),
        .ether_type    (ether_type),
        .ip_protocol   (ip_protocol),
        .source_port   (source_port),
        .dest_port     (dest_port),
        .icmp_kind     (icmp_kind),
        .arp_operation (arp_operation)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver side: random stall per cycle at the current phase's rate
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic clear_frame_state();
        seen_count = 8'd0;
        seen_type  = 16'd0;
        seen_ihl   = 4'd0;
        seen_proto = 8'd0;
        seen_doff  = 4'd0;
        seen_sport = 16'd0;
        seen_dport = 16'd0;
        seen_icmp  = 8'd0;
        seen_arp   = 16'd0;
    endtask

    // update the capture state for one accepted byte; on the last byte classify the frame
    task automatic track_frame_byte(input logic [7:0] b, input logic l);
        int pos;
        int l4;
        int total;
        int rem;
        frame_summary_t s;
        pos = seen_count;
        l4  = ETH_LEN + WORD_BYTES * seen_ihl;
        if (pos == POS_TYPE_HI) seen_type[15:8] = b;
        if (pos == POS_TYPE_LO) seen_type[7:0] = b;
        if (pos == POS_IHL)     seen_ihl = b[3:0];
        if (pos == POS_ARP_HI)  seen_arp[15:8] = b;
        if (pos == POS_ARP_LO)  seen_arp[7:0] = b;
        if (pos == POS_PROTO)   seen_proto = b;
        // layer 4 offsets only count once the ihl byte is behind us
        if (pos > POS_IHL)
        begin
            if (pos == l4)
            begin
                seen_sport[15:8] = b;
                seen_icmp = b;
            end
            if (pos == l4 + 1) seen_sport[7:0] = b;
            if (pos == l4 + 2) seen_dport[15:8] = b;
            if (pos == l4 + 3) seen_dport[7:0] = b;
            if (pos == l4 + POS_DOFF) seen_doff = b[7:4];
        end
        if (seen_count != COUNT_MAX) seen_count = seen_count + 8'd1;
        if (!l) return;

        s = '0;
        total = seen_count;
        if (total >= ETH_LEN)
        begin
            s.etype = seen_type;
            s.ok = 1'b1;
            if (seen_type == TYPE_IPV4)
            begin
                if (total < ETH_LEN + IP_MIN_LEN || seen_ihl < MIN_WORDS || total < l4)
                begin
                    s.ok = 1'b0;
                end
                else
                begin
                    s.proto = seen_proto;
                    rem = total - l4;
                    if (seen_proto == PROTO_TCP)
                    begin
                        if (rem < TCP_MIN_LEN || seen_doff < MIN_WORDS
                            || rem < WORD_BYTES * seen_doff)
                            s.ok = 1'b0;
                        else
                        begin
                            s.cat = CAT_TCP;
                            s.sport = seen_sport;
                            s.dport = seen_dport;
                        end
                    end
                    else if (seen_proto == PROTO_UDP)
                    begin
                        if (rem < UDP_LEN)
                            s.ok = 1'b0;
                        else
                        begin
                            s.cat = CAT_UDP;
                            s.sport = seen_sport;
                            s.dport = seen_dport;
                        end
                    end
                    else if (seen_proto == PROTO_ICMP)
                    begin
                        if (rem < ICMP_LEN)
                            s.ok = 1'b0;
                        else
                        begin
                            s.cat = CAT_ICMP;
                            s.icmp = seen_icmp;
                        end
                    end
                end
            end
            else if (seen_type == TYPE_ARP)
            begin
                if (total < ARP_FRAME_LEN)
                    s.ok = 1'b0;
                else
                begin
                    s.cat = CAT_ARP;
                    s.arp_op = seen_arp;
                end
            end
        end
        expected_summaries.push_back(s);
        clear_frame_state();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // compare every result transaction with the oldest predicted summary
    always @(posedge clk)
    begin
        frame_summary_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_summaries.size() == 0)
            begin
                $display("%0t unexpected result transaction, nothing predicted", $time);
                error_count++;
            end
            else
            begin
                want = expected_summaries.pop_front();
                check_field("parse_ok", 16'(want.ok), 16'(parse_ok));
                check_field("category", 16'(want.cat), 16'(category));
                check_field("ether_type", want.etype, ether_type);
                check_field("ip_protocol", 16'(want.proto), 16'(ip_protocol));
                check_field("source_port", want.sport, source_port);
                check_field("dest_port", want.dport, dest_port);
                check_field("icmp_kind", 16'(want.icmp), 16'(icmp_kind));
                check_field("arp_operation", want.arp_op, arp_operation);
            end
        end
    end

    // one byte transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= l;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        track_frame_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_byte(pkt[i], i == len - 1);
    endtask

    // fill pkt with random content and place the headers that the kind asks for; need
    // is the shortest passing length when ihl and doff are at least 5, random for noise
    task automatic shape_frame(input frame_kind_t kind, input int ihl, input int doff,
                               output int need);
        int l4;
        for (int i = 0; i < FRAME_MAX; i++) pkt[i] = 8'($urandom);
        l4 = ETH_LEN + WORD_BYTES * ihl;
        need = ETH_LEN;
        case (kind)
            FRAME_TCP, FRAME_UDP, FRAME_ICMP, FRAME_OTHER_PROTO:
            begin
                pkt[POS_TYPE_HI] = TYPE_IPV4[15:8];
                pkt[POS_TYPE_LO] = TYPE_IPV4[7:0];
                pkt[POS_IHL] = {4'h4, 4'(ihl)};
                pkt[l4 + POS_DOFF][7:4] = 4'(doff);
                need = (l4 > ETH_LEN + IP_MIN_LEN) ? l4 : ETH_LEN + IP_MIN_LEN;
                if (kind == FRAME_TCP)
                begin
                    pkt[POS_PROTO] = PROTO_TCP;
                    need = l4 + ((WORD_BYTES * doff > TCP_MIN_LEN) ?
                                 WORD_BYTES * doff : TCP_MIN_LEN);
                end
                else if (kind == FRAME_UDP)
                begin
                    pkt[POS_PROTO] = PROTO_UDP;
                    need = l4 + UDP_LEN;
                end
                else if (kind == FRAME_ICMP)
                begin
                    pkt[POS_PROTO] = PROTO_ICMP;
                    need = l4 + ICMP_LEN;
                end
            end
            FRAME_ARP:
            begin
                pkt[POS_TYPE_HI] = TYPE_ARP[15:8];
                pkt[POS_TYPE_LO] = TYPE_ARP[7:0];
                need = ARP_FRAME_LEN;
            end
            FRAME_OTHER_TYPE:
                pkt[POS_TYPE_HI] = 8'($urandom_range(9, 255));
            default:
                need = $urandom_range(1, 60);
        endcase
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (expected_summaries.size() != 0) @(posedge clk);
    endtask

    task automatic directed_frame(input frame_kind_t kind, input int ihl, input int doff,
                                  input int delta);
        int need;
        shape_frame(kind, ihl, doff, need);
        send_frame(need + delta);
    endtask

    // every category at its exact length and one byte short, header word limits,
    // short frames, unknown types, saturation and the data byte extremes
    task automatic test_directed();
        int need;
        idle_pct = 0;
        stall_pct = 0;
        directed_frame(FRAME_TCP, 5, 5, 0);
        directed_frame(FRAME_TCP, 5, 5, -1);
        directed_frame(FRAME_TCP, 15, 15, 0);
        directed_frame(FRAME_TCP, 15, 15, -1);
        directed_frame(FRAME_TCP, 5, 4, 10);
        directed_frame(FRAME_UDP, 5, 0, 0);
        directed_frame(FRAME_UDP, 5, 0, -1);
        directed_frame(FRAME_ICMP, 6, 0, 0);
        directed_frame(FRAME_ICMP, 5, 0, -1);
        directed_frame(FRAME_ARP, 5, 5, 0);
        directed_frame(FRAME_ARP, 5, 5, -1);
        directed_frame(FRAME_OTHER_TYPE, 5, 5, 0);
        directed_frame(FRAME_OTHER_TYPE, 5, 5, -1);
        directed_frame(FRAME_OTHER_PROTO, 5, 5, 0);
        // ip header shorter than the minimum, and ihl 4 and ihl 0 with a long frame
        directed_frame(FRAME_UDP, 5, 0, -9);
        directed_frame(FRAME_UDP, 4, 0, 30);
        directed_frame(FRAME_UDP, 0, 0, 30);
        // single byte frame fails the ethernet check
        shape_frame(FRAME_NOISE, 5, 5, need);
        send_frame(1);
        // longer than the counter: length taken as 255
        directed_frame(FRAME_TCP, 5, 5, 260 - 54);
        directed_frame(FRAME_UDP, 15, 0, 260 - 82);
        shape_frame(FRAME_NOISE, 5, 5, need);
        for (int i = 0; i < FRAME_MAX; i++) pkt[i] = 8'hFF;
        send_frame(40);
        for (int i = 0; i < FRAME_MAX; i++) pkt[i] = 8'h00;
        send_frame(40);
        wait_drained();
    endtask

    task automatic random_frame();
        frame_kind_t kind;
        int ihl;
        int doff;
        int need;
        int len;
        int roll;
        kind = frame_kind_t'($urandom_range(0, 6));
        if ($urandom_range(0, 2) == 0) kind = FRAME_TCP;
        ihl  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
        doff = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
        shape_frame(kind, ihl, doff, need);
        roll = $urandom_range(0, 49);
        if (roll == 0)
            len = $urandom_range(250, FRAME_MAX);
        else if (roll < 6)
            len = $urandom_range(1, 90);
        else
            len = need + $urandom_range(0, 9) - 3;
        if (len < 1) len = 1;
        if (len > FRAME_MAX) len = FRAME_MAX;
        send_frame(len);
    endtask

    // mostly well-formed frames near their length limits, some truncated or noise
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int byte_goal);
        int start_bytes;
        int frames;
        idle_pct = sender_pct;
        stall_pct = receiver_pct;
        start_bytes = bytes_sent;
        frames = 0;
        while (bytes_sent - start_bytes < byte_goal || frames < 2)
        begin
            random_frame();
            frames++;
        end
    endtask

    // sender holds off until every result is back, then resumes
    task automatic test_pause_until_drained();
        idle_pct = 0;
        stall_pct = 85;
        for (int i = 0; i < 2; i++) random_frame();
        wait_drained();
        for (int i = 0; i < 2; i++) random_frame();
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(0, 0, 125);
        test_random_traffic(85, 0, 125);
        test_random_traffic(0, 85, 125);
        test_random_traffic(17, 17, 125);
        test_pause_until_drained();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
